// File: rtl/binary_trie_longest_prefix_match_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary trie longest prefix match block
// Concurrent property wrappers with a common clock, reset and report.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH

// antecedent and consequent in the same cycle
`define BTLPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("btlpm assertion failed");

// consequent in the cycle after the antecedent
`define BTLPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("btlpm assertion failed");

`endif

// File: rtl/btlpm_pkg.sv
// ----------------------------------------------------------------------------
// btlpm_pkg
// Shared types and constants of the binary trie longest prefix match block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package btlpm_pkg;

    localparam int ADDR_W      = 32;
    localparam int ROUTE_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 24;

    // input tdata field positions
    localparam int IN_ADDR_LSB  = 0;
    localparam int IN_MASK_LSB  = 32;
    localparam int IN_ROUTE_LSB = 64;

    localparam int OUT_PAD_W = OUT_TDATA_W - ROUTE_W - STATUS_W;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_ALLOC,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// File: rtl/binary_trie_longest_prefix_match.sv
// A lookup is accepted in S_IDLE, walks the trie in S_WALK one level per node read, then loads its result in S_FIN.
// An insert walks the same way and also passes through S_ALLOC once for each node it allocates.
// One item in flight: the next item is accepted only after the result has loaded and the block is back in S_IDLE.
// Node memory port sets the pace: one node read (and at most one write) per cycle.
// Reset: the S_INIT state clears the root node, input ready stays low meanwhile; node allocation restarts.
// ----------------------------------------------------------------------------
// binary_trie_longest_prefix_match
// Unibit binary trie in a single-port-style node memory: route insert and
// longest prefix lookup, one walk step per node read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_trie_longest_prefix_match #(
    parameter int NODE_COUNT   = 4096,
    parameter int ADDRESS_BITS = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // address [31:0], netmask [63:32], route_number [79:64]
    input  wire  [btlpm_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // kind [0]
    input  wire  [0:0]                      i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // status [1:0], matched_route [17:2], zero pad [23:18]
    output logic [btlpm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    import btlpm_pkg::*;

    localparam int NW = $clog2(NODE_COUNT);
    localparam int FW = $clog2(NODE_COUNT + 1);
    localparam int LW = $clog2(ADDRESS_BITS + 1);
    localparam int EW = 2 * NW + 1 + ROUTE_W;

    // node entry: child0 [NW-1:0], child1 [2NW-1:NW], has_route [2NW], route above
    logic [EW-1:0]       r_node_mem [NODE_COUNT];
    logic [EW-1:0]       r_rd_data;

    t_state              r_state, n_state;
    logic                r_kind, n_kind;
    logic [ADDRESS_BITS-1:0] r_addr, n_addr;
    logic [ADDRESS_BITS-1:0] r_mask, n_mask;
    logic [ROUTE_W-1:0]  r_route_in, n_route_in;
    logic [NW-1:0]       r_cur, n_cur;
    logic [LW-1:0]       r_level, n_level;
    logic [FW-1:0]       r_free, n_free;
    logic                r_found, n_found;
    logic [ROUTE_W-1:0]  r_best, n_best;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [ROUTE_W-1:0]  r_out_route;

    logic                mem_rd_en;
    logic                mem_rd_clr;
    logic [NW-1:0]       mem_rd_addr;
    logic                mem_wr_en;
    logic [NW-1:0]       mem_wr_addr;
    logic [EW-1:0]       mem_wr_data;
    logic                out_load;

    logic [NW-1:0]       nd_child0, nd_child1, nd_next;
    logic                nd_has;
    logic [ROUTE_W-1:0]  nd_route;
    logic                walk_bit;
    logic                at_bottom;
    logic                look_found;
    logic [ROUTE_W-1:0]  look_best;

    assign nd_child0 = r_rd_data[NW-1:0];
    assign nd_child1 = r_rd_data[2*NW-1:NW];
    assign nd_has    = r_rd_data[2*NW];
    assign nd_route  = r_rd_data[EW-1:2*NW+1];
    assign walk_bit  = r_addr[ADDRESS_BITS-1];
    assign nd_next   = walk_bit ? nd_child1 : nd_child0;
    assign at_bottom = (r_level == LW'(ADDRESS_BITS));

    assign look_found = r_found | nd_has;
    assign look_best  = nd_has ? nd_route : r_best;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_route, r_out_status};

    // node memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_wr_en) begin
            r_node_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            r_rd_data <= r_node_mem[mem_rd_addr];
        end else if (mem_rd_clr) begin
            r_rd_data <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_free      <= FW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_free  <= n_free;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_addr     <= n_addr;
        r_mask     <= n_mask;
        r_route_in <= n_route_in;
        r_cur      <= n_cur;
        r_level    <= n_level;
        r_found    <= n_found;
        r_best     <= n_best;
        r_status   <= n_status;
        if (out_load) begin
            r_out_status <= r_status;
            r_out_route  <= r_best;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_mask      = r_mask;
        n_route_in  = r_route_in;
        n_cur       = r_cur;
        n_level     = r_level;
        n_free      = r_free;
        n_found     = r_found;
        n_best      = r_best;
        n_status    = r_status;
        mem_rd_en   = 1'b0;
        mem_rd_clr  = 1'b0;
        mem_rd_addr = nd_next;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_cur;
        mem_wr_data = r_rd_data;
        out_load    = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // clear the root node
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                mem_wr_data = '0;
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind      = i_s_axis_tuser[0];
                    n_addr      = i_s_axis_tdata[IN_ADDR_LSB +: ADDRESS_BITS];
                    n_mask      = i_s_axis_tdata[IN_MASK_LSB +: ADDRESS_BITS];
                    n_route_in  = i_s_axis_tdata[IN_ROUTE_LSB +: ROUTE_W];
                    n_cur       = '0;
                    n_level     = '0;
                    n_found     = 1'b0;
                    n_best      = '0;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = '0;
                    n_state     = S_WALK;
                end
            end
            S_WALK: begin
                if (r_kind == KIND_LOOKUP) begin
                    if (at_bottom || nd_next == '0) begin
                        n_status = look_found ? ST_HIT : ST_MISS;
                        n_best   = look_found ? look_best : '0;
                        n_state  = S_FIN;
                    end else begin
                        n_found   = look_found;
                        n_best    = look_best;
                        mem_rd_en = 1'b1;
                        n_cur     = nd_next;
                        n_level   = r_level + LW'(1);
                        n_addr    = r_addr << 1;
                    end
                end else begin
                    n_best = '0;
                    priority if (at_bottom || !r_mask[ADDRESS_BITS-1]) begin
                        // prefix node reached: mark the route, keep the children
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {r_route_in, 1'b1, nd_child1, nd_child0};
                        n_status    = ST_INSERTED;
                        n_state     = S_FIN;
                    end else if (nd_next != '0) begin
                        mem_rd_en = 1'b1;
                        n_cur     = nd_next;
                        n_level   = r_level + LW'(1);
                        n_addr    = r_addr << 1;
                        n_mask    = r_mask << 1;
                    end else if (r_free == FW'(NODE_COUNT)) begin
                        n_status = ST_FULL;
                        n_state  = S_FIN;
                    end else begin
                        // link the next free node into the parent
                        mem_wr_en   = 1'b1;
                        mem_wr_data = walk_bit
                                    ? {nd_route, nd_has, r_free[NW-1:0], nd_child0}
                                    : {nd_route, nd_has, nd_child1, r_free[NW-1:0]};
                        n_state     = S_ALLOC;
                    end
                end
            end
            S_ALLOC: begin
                // clear the new node and descend into it without a read
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_free[NW-1:0];
                mem_wr_data = '0;
                mem_rd_clr  = 1'b1;
                n_cur       = r_free[NW-1:0];
                n_free      = r_free + FW'(1);
                n_level     = r_level + LW'(1);
                n_addr      = r_addr << 1;
                n_mask      = r_mask << 1;
                n_state     = S_WALK;
            end
            S_FIN: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/btlpm_checker.sv
// ----------------------------------------------------------------------------
// btlpm_checker
// Port-level checks of the binary trie longest prefix match block, bound to
// the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "binary_trie_longest_prefix_match_assert.svh"

module btlpm_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_axis_tvalid,
    input wire                             o_s_axis_tready,
    input wire                             o_m_axis_tvalid,
    input wire                             i_m_axis_tready,
    // status [1:0], matched_route [17:2], zero pad [23:18]
    input wire [btlpm_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    import btlpm_pkg::*;

    logic [STATUS_W-1:0] out_status;
    logic [ROUTE_W-1:0]  out_route;

    assign out_status = o_m_axis_tdata[STATUS_W-1:0];
    assign out_route  = o_m_axis_tdata[STATUS_W +: ROUTE_W];

    `BTLPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))

    `BTLPM_ASSERT_SAME(a_route_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && (out_status == ST_INSERTED || out_status == ST_FULL ||
        out_status == ST_MISS),
        out_route == '0)

    `BTLPM_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n,
        i_s_axis_tvalid && o_s_axis_tready,
        !o_s_axis_tready)

    `BTLPM_ASSERT_SAME(a_result_after_work, i_clk, i_rst_n,
        $rose(o_m_axis_tvalid),
        $past(!o_s_axis_tready))

endmodule

bind binary_trie_longest_prefix_match btlpm_checker u_btlpm_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: binary trie longest prefix match testbench
// Drives route inserts and address lookups over the input stream and keeps a
// trie of its own to predict each status and matched route. Directed items hit
// the root route, overwrites, odd masks and both address extremes; random
// phases build a routing table and look up addresses under it; a last phase
// fills the node store. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import btlpm_pkg::*;

    localparam int NODES       = 4096;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ROUTE_W-1:0]  route;
    } trie_result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] mask;
    } route_entry_t;

    // Shadow trie: predicts the block and checks what it returns.
    class trie_scoreboard;
        int unsigned        child_lo[NODES];
        int unsigned        child_hi[NODES];
        bit                 route_valid[NODES];
        logic [ROUTE_W-1:0] route_id[NODES];
        int unsigned        next_free;
        trie_result_t       pending[$];
        int                 errors;
        int                 checked;
        int                 n_inserted;
        int                 n_full;
        int                 n_hit;
        int                 n_miss;

        function new();
            child_lo[0]    = 0;
            child_hi[0]    = 0;
            route_valid[0] = 1'b0;
            route_id[0]    = '0;
            next_free      = 1;
        endfunction

        function int unsigned mask_length(logic [ADDR_W-1:0] mask);
            int unsigned n;
            n = 0;
            while (n < ADDR_W && mask[ADDR_W-1-n])
                n++;
            return n;
        endfunction

        function logic [STATUS_W-1:0] insert_route(logic [ADDR_W-1:0] prefix,
                                                   logic [ADDR_W-1:0] mask,
                                                   logic [ROUTE_W-1:0] route);
            int unsigned len;
            int unsigned cur;
            int unsigned nxt;
            int unsigned lvl;
            bit          b;
            len = mask_length(mask);
            cur = 0;
            for (lvl = 0; lvl < len; lvl++) begin
                b   = prefix[ADDR_W-1-lvl];
                nxt = b ? child_hi[cur] : child_lo[cur];
                if (nxt == 0) begin
                    // earlier nodes of this walk stay linked
                    if (next_free >= NODES)
                        return ST_FULL;
                    nxt = next_free;
                    next_free++;
                    child_lo[nxt]    = 0;
                    child_hi[nxt]    = 0;
                    route_valid[nxt] = 1'b0;
                    route_id[nxt]    = '0;
                    if (b)
                        child_hi[cur] = nxt;
                    else
                        child_lo[cur] = nxt;
                end
                cur = nxt;
            end
            route_valid[cur] = 1'b1;
            route_id[cur]    = route;
            return ST_INSERTED;
        endfunction

        function trie_result_t longest_match(logic [ADDR_W-1:0] dest);
            trie_result_t res;
            int unsigned  cur;
            int unsigned  nxt;
            int unsigned  lvl;
            bit           found;
            found     = route_valid[0];
            res.route = route_id[0];
            cur       = 0;
            for (lvl = 0; lvl < ADDR_W; lvl++) begin
                nxt = dest[ADDR_W-1-lvl] ? child_hi[cur] : child_lo[cur];
                if (nxt == 0)
                    break;
                cur = nxt;
                if (route_valid[cur]) begin
                    found     = 1'b1;
                    res.route = route_id[cur];
                end
            end
            res.status = found ? ST_HIT : ST_MISS;
            if (!found)
                res.route = '0;
            return res;
        endfunction

        function logic [STATUS_W-1:0] note_request(logic kind, logic [ADDR_W-1:0] addr,
                                                   logic [ADDR_W-1:0] mask,
                                                   logic [ROUTE_W-1:0] route);
            trie_result_t res;
            if (kind == KIND_INSERT) begin
                res.status = insert_route(addr, mask, route);
                res.route  = '0;
                if (res.status == ST_FULL)
                    n_full++;
                else
                    n_inserted++;
            end else begin
                res = longest_match(addr);
                if (res.status == ST_HIT)
                    n_hit++;
                else
                    n_miss++;
            end
            pending.push_back(res);
            return res.status;
        endfunction

        function void report(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [ROUTE_W-1:0] route);
            trie_result_t want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d route 0x%0h",
                         $time, status, route);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (status !== want.status)
                report("status", want.status, status);
            if (route !== want.route)
                report("matched_route", want.route, route);
        endfunction
    endclass

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [0:0]             i_s_axis_tuser  = '0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    trie_scoreboard sb = new();
    route_entry_t   known_routes[$];
    bit             calm = 1'b0;
    int             idle_cycles = 0;

    binary_trie_longest_prefix_match #(
        .NODE_COUNT   (NODES),
        .ADDRESS_BITS (ADDR_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        else if (r < 85)
            return $urandom_range(2, 4);
        else if (r < 96)
            return $urandom_range(5, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ADDR_W-1:0] prefix_mask(int unsigned len);
        return {ADDR_W{1'b1}} << (ADDR_W - len);
    endfunction

    task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr,
                             input logic [ADDR_W-1:0] mask, input logic [ROUTE_W-1:0] route);
        int                  gap;
        int unsigned         len;
        logic [STATUS_W-1:0] st;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {route, mask, addr};
        i_s_axis_tuser  <= kind;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        st = sb.note_request(kind, addr, mask, route);
        if (kind == KIND_INSERT && st == ST_INSERTED) begin
            len = sb.mask_length(mask);
            known_routes.push_back('{prefix: addr & prefix_mask(len),
                                     mask: prefix_mask(len)});
        end
    endtask

    // hold the sender until the block has returned everything
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_insert();
        int unsigned       len;
        int                r;
        logic [ADDR_W-1:0] mask;
        logic [ROUTE_W-1:0] route;
        r = $urandom_range(0, 99);
        if (r < 15)
            len = $urandom_range(0, 8);
        else if (r < 70)
            len = $urandom_range(9, 24);
        else
            len = $urandom_range(25, 32);
        mask = prefix_mask(len);
        // noise below the leading ones must not change the prefix length
        if ($urandom_range(0, 9) == 0)
            mask = mask | ($urandom & (~prefix_mask(len) >> 1));
        route = $urandom;
        if ($urandom_range(0, 19) == 0)
            route = $urandom_range(0, 1) ? '1 : '0;
        send_item(KIND_INSERT, $urandom, mask, route);
    endtask

    task automatic send_overwrite();
        route_entry_t e;
        e = known_routes[$urandom_range(0, known_routes.size() - 1)];
        send_item(KIND_INSERT, e.prefix | ($urandom & ~e.mask), e.mask, $urandom);
    endtask

    task automatic send_random_lookup();
        route_entry_t      e;
        logic [ADDR_W-1:0] dest;
        dest = $urandom;
        if (known_routes.size() != 0 && $urandom_range(0, 99) < 55) begin
            e    = known_routes[$urandom_range(0, known_routes.size() - 1)];
            dest = e.prefix | (dest & ~e.mask);
        end
        send_item(KIND_LOOKUP, dest, $urandom, $urandom);
    endtask

    // result side: random stalls, none while calm
    initial begin : result_sink
        int   stall_left;
        logic ready_next;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left != 0) begin
                ready_next = 1'b0;
                stall_left--;
            end else begin
                ready_next = 1'b1;
            end
            i_m_axis_tready <= ready_next;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata[STATUS_W-1:0], o_m_axis_tdata[STATUS_W +: ROUTE_W]);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, sb.pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        int r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, root route, nesting, overwrite, odd masks, extremes
        calm = 1'b1;
        send_item(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        send_item(KIND_INSERT, 32'hDEAD_BEEF, 32'h0000_0000, 16'h1234);
        send_item(KIND_LOOKUP, 32'h5A5A_A5A5, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(KIND_INSERT, 32'h0A00_0000, 32'hFF00_0000, 16'hFFFF);
        send_item(KIND_INSERT, 32'h0A01_0000, 32'hFFFF_0000, 16'h0000);
        send_item(KIND_LOOKUP, 32'h0A01_0203, 32'h0000_0000, 16'h0000);
        send_item(KIND_LOOKUP, 32'h0A02_0000, 32'h0000_0000, 16'h0000);
        send_item(KIND_INSERT, 32'h0A00_0000, 32'hFF00_0000, 16'h00AA);
        send_item(KIND_LOOKUP, 32'h0AC8_0001, 32'h0000_0000, 16'h0000);
        send_item(KIND_INSERT, 32'hC0A8_FFFF, 32'hFF00_FF00, 16'h5555);
        send_item(KIND_LOOKUP, 32'hC000_0000, 32'h0000_0000, 16'h0000);
        calm = 1'b0;
        send_item(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hAAAA);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFE, 32'h0000_0000, 16'h0000);
        send_item(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0001);
        send_item(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        send_item(KIND_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 16'h0002);
        send_item(KIND_LOOKUP, 32'h1234_5678, 32'h0000_0000, 16'h0000);
        send_item(KIND_INSERT, 32'h0000_0001, 32'hFFFF_FFFE, 16'h0003);
        send_item(KIND_LOOKUP, 32'h0000_0001, 32'h0000_0000, 16'h0000);
        send_item(KIND_LOOKUP, 32'h0000_0000, 32'h0000_0000, 16'h0000);
        send_item(KIND_LOOKUP, 32'h8000_0000, 32'h0000_0000, 16'h0000);
        drain_results();

        // random table build and lookups, one calm phase, the rest with idling
        for (phase = 0; phase < 4; phase++) begin
            calm = (phase == 0);
            for (n = 0; n < 175; n++) begin
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                r = $urandom_range(0, 99);
                if (r < 35)
                    send_random_insert();
                else if (r < 42 && known_routes.size() != 0)
                    send_overwrite();
                else
                    send_random_lookup();
            end
            drain_results();
        end

        // fill the node store with host routes until inserts start to fail
        n = 0;
        while (sb.n_full < 4 && n < 600) begin
            if ($urandom_range(0, 4) == 0)
                send_random_lookup();
            else
                send_item(KIND_INSERT, $urandom, 32'hFFFF_FFFF, $urandom);
            n++;
        end
        for (n = 0; n < 30; n++) begin
            r = $urandom_range(0, 2);
            if (r == 0)
                send_overwrite();
            else if (r == 1)
                send_random_insert();
            else
                send_random_lookup();
        end

        drain_results();
        repeat (80) @(posedge i_clk);
        $display("Checked %0d results: %0d inserted, %0d store full, %0d hits, %0d misses.",
                 sb.checked, sb.n_inserted, sb.n_full, sb.n_hit, sb.n_miss);
        $display("Trie grew to %0d of %0d nodes; %0d mismatches.",
                 sb.next_free, NODES, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: binary_trie_longest_prefix_match.f
+incdir+rtl
rtl/btlpm_pkg.sv
rtl/binary_trie_longest_prefix_match.sv
rtl/btlpm_checker.sv
tb/tb_top.sv
